// ----- rtl/iad_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iad_pkg: shared types and constants of the integer calculator
// Field widths, operation codes, status codes and sequencer states.
// ----------------------------------------------------------------------------
package iad_pkg;

    localparam int DataW    = 32;
    localparam int KindW    = 8;
    localparam int OperandW = 31;
    localparam int ResultW  = 32;
    localparam int StatusW  = 2;
    localparam int OpW      = (DataW > OperandW) ? DataW : OperandW;
    localparam int CntW     = $clog2(OpW);
    localparam int PowSteps = OperandW;

    localparam logic [KindW-1:0] OPC_ADD = 8'h2B;
    localparam logic [KindW-1:0] OPC_SUB = 8'h2D;
    localparam logic [KindW-1:0] OPC_DIV = 8'h2F;
    localparam logic [KindW-1:0] OPC_MUL = 8'h78;
    localparam logic [KindW-1:0] OPC_POW = 8'h5E;

    typedef enum logic [StatusW-1:0] {
        STAT_OK      = 2'd0,
        STAT_DIV0    = 2'd1,
        STAT_UNKNOWN = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIV,
        ST_POW,
        ST_DONE
    } t_state;

    function automatic logic [DataW-1:0] to_dw(input logic [OperandW-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[DataW-1:0];
    endfunction

    function automatic logic [ResultW-1:0] to_res(input logic [DataW-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[ResultW-1:0];
    endfunction

endpackage

// ----- rtl/iad_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iad_req_if: request channel
// Valid/ready channel carrying the operation code and both operands.
// ----------------------------------------------------------------------------
interface iad_req_if;

    logic                          valid;
    logic                          ready;
    logic [iad_pkg::KindW-1:0]     kind;
    logic [iad_pkg::OperandW-1:0]  first_operand;
    logic [iad_pkg::OperandW-1:0]  second_operand;

    modport source (output valid, output kind, output first_operand,
                    output second_operand, input ready);
    modport sink   (input valid, input kind, input first_operand,
                    input second_operand, output ready);

endinterface

// ----- rtl/iad_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iad_rsp_if: response channel
// Valid/ready channel carrying the result value and the status code.
// ----------------------------------------------------------------------------
interface iad_rsp_if;

    logic                               valid;
    logic                               ready;
    logic signed [iad_pkg::ResultW-1:0] result_value;
    logic [iad_pkg::StatusW-1:0]        status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);

endinterface

// ----- rtl/integer_alu_div_pow.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_alu_div_pow: sequential integer calculator
// Add, subtract, multiply, restoring divide and square-and-multiply power
// on one shared multiplier and one shared adder/subtractor.
// ----------------------------------------------------------------------------
// Path to result valid: add/sub/mul pass ST_EXEC, divide loops in ST_DIV,
// power in ST_POW; divide by zero and unknown codes go straight to ST_DONE.
// Throughput: one item at a time; the divide loop (one bit per cycle) and
// the power loop (two multiplies per exponent bit) set the interval.
// A finished result waits in the output register while the next item runs.
// Reset (synchronous, active low) returns the sequencer to idle, drops out.
// ----------------------------------------------------------------------------
module integer_alu_div_pow (
    input  logic     i_clk,
    input  logic     i_rst_n,
    iad_req_if.sink   i_req,
    iad_rsp_if.source o_rsp
);

    localparam int DW = iad_pkg::DataW;

    iad_pkg::t_state               r_state,  n_state;
    logic [iad_pkg::KindW-1:0]     r_kind,   n_kind;
    logic [DW-1:0]                 r_a,      n_a;
    logic [iad_pkg::OpW-1:0]       r_b,      n_b;
    logic [DW-1:0]                 r_acc,    n_acc;
    logic [iad_pkg::CntW-1:0]      r_cnt,    n_cnt;
    logic                          r_phase,  n_phase;
    iad_pkg::t_status              r_stat,   n_stat;

    logic                          r_out_valid;
    logic [iad_pkg::ResultW-1:0]   r_out_value;
    iad_pkg::t_status              r_out_status;

    logic                          req_xfer;
    logic                          out_free;
    logic [DW-1:0]                 a_in;
    logic [DW-1:0]                 b_in;

    logic [DW-1:0]                 mul_x, mul_y;
    logic [2*DW-1:0]               mul_p;
    logic [DW:0]                   add_x, add_y, add_s;
    logic                          add_sub;
    logic                          trial_neg;

    assign req_xfer = i_req.valid && i_req.ready;
    assign out_free = !r_out_valid || o_rsp.ready;
    assign a_in     = iad_pkg::to_dw(i_req.first_operand);
    assign b_in     = iad_pkg::to_dw(i_req.second_operand);

    assign i_req.ready        = (r_state == iad_pkg::ST_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_out_value;
    assign o_rsp.status       = r_out_status;

    // shared arithmetic
    assign mul_p     = (2*DW)'(mul_x) * (2*DW)'(mul_y);
    assign add_s     = add_x + (add_sub ? ~add_y : add_y) + (DW+1)'(add_sub);
    assign trial_neg = add_s[DW];

    always_comb begin
        mul_x   = r_a;
        mul_y   = r_b[DW-1:0];
        add_x   = {1'b0, r_a};
        add_y   = {1'b0, r_b[DW-1:0]};
        add_sub = (r_kind == iad_pkg::OPC_SUB);
        unique case (r_state)
            iad_pkg::ST_DIV: begin
                add_x   = {r_acc, r_a[DW-1]};
                add_sub = 1'b1;
            end
            iad_pkg::ST_POW: begin
                if (!r_phase) begin
                    mul_x = r_acc;
                    mul_y = r_a;
                end else begin
                    mul_x = r_a;
                    mul_y = r_a;
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            iad_pkg::ST_IDLE: begin
                if (req_xfer) begin
                    unique case (i_req.kind) inside
                        iad_pkg::OPC_ADD, iad_pkg::OPC_SUB,
                        iad_pkg::OPC_MUL: n_state = iad_pkg::ST_EXEC;
                        iad_pkg::OPC_DIV: n_state = (b_in == '0) ? iad_pkg::ST_DONE
                                                                 : iad_pkg::ST_DIV;
                        iad_pkg::OPC_POW: n_state = iad_pkg::ST_POW;
                        default:          n_state = iad_pkg::ST_DONE;
                    endcase
                end
            end
            iad_pkg::ST_EXEC: n_state = iad_pkg::ST_DONE;
            iad_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = iad_pkg::ST_DONE;
                end
            end
            iad_pkg::ST_POW: begin
                if (r_phase && r_cnt == '0) begin
                    n_state = iad_pkg::ST_DONE;
                end
            end
            iad_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = iad_pkg::ST_IDLE;
                end
            end
            default: n_state = iad_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_kind  = r_kind;
        n_a     = r_a;
        n_b     = r_b;
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_phase = r_phase;
        n_stat  = r_stat;
        unique case (r_state)
            iad_pkg::ST_IDLE: begin
                if (req_xfer) begin
                    n_kind  = i_req.kind;
                    n_a     = a_in;
                    n_b     = iad_pkg::OpW'(i_req.second_operand);
                    n_acc   = '0;
                    n_phase = 1'b0;
                    n_stat  = iad_pkg::STAT_OK;
                    n_cnt   = iad_pkg::CntW'(DW - 1);
                    unique case (i_req.kind) inside
                        iad_pkg::OPC_ADD, iad_pkg::OPC_SUB, iad_pkg::OPC_MUL: begin
                            n_b = iad_pkg::OpW'(b_in);
                        end
                        iad_pkg::OPC_DIV: begin
                            n_b = iad_pkg::OpW'(b_in);
                            if (b_in == '0) begin
                                n_a    = '0;
                                n_stat = iad_pkg::STAT_DIV0;
                            end
                        end
                        iad_pkg::OPC_POW: begin
                            n_acc = DW'(1);
                            n_cnt = iad_pkg::CntW'(iad_pkg::PowSteps - 1);
                        end
                        default: begin
                            n_stat = iad_pkg::STAT_UNKNOWN;
                        end
                    endcase
                end
            end
            iad_pkg::ST_EXEC: begin
                n_acc = (r_kind == iad_pkg::OPC_MUL) ? mul_p[DW-1:0] : add_s[DW-1:0];
            end
            iad_pkg::ST_DIV: begin
                n_acc = trial_neg ? add_x[DW-1:0] : add_s[DW-1:0];
                n_a   = {r_a[DW-2:0], ~trial_neg};
                n_cnt = r_cnt - 1'b1;
            end
            iad_pkg::ST_POW: begin
                if (!r_phase) begin
                    if (r_b[0]) begin
                        n_acc = mul_p[DW-1:0];
                    end
                end else begin
                    n_a   = mul_p[DW-1:0];
                    n_b   = r_b >> 1;
                    n_cnt = r_cnt - 1'b1;
                end
                n_phase = ~r_phase;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iad_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_kind  <= n_kind;
        r_a     <= n_a;
        r_b     <= n_b;
        r_acc   <= n_acc;
        r_cnt   <= n_cnt;
        r_phase <= n_phase;
        r_stat  <= n_stat;
    end

    // output register: load on finish, drop on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == iad_pkg::ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
        if (r_state == iad_pkg::ST_DONE && out_free) begin
            r_out_value  <= iad_pkg::to_res((r_kind == iad_pkg::OPC_DIV) ? r_a : r_acc);
            r_out_status <= r_stat;
        end
    end

`ifndef SYNTHESIS
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_xfer |=> !i_req.ready)
        else $error("request taken while an item is in work");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != iad_pkg::STAT_OK) |-> (o_rsp.result_value == '0))
        else $error("error status with nonzero result");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == iad_pkg::ST_DIV && r_cnt == '0) |=> (r_state == iad_pkg::ST_DONE))
        else $error("divide loop overran");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == iad_pkg::ST_DONE))
        else $error("result loaded outside finish state");
`endif

endmodule
